// ----- hw/rtl/dpht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpht_pkg: shared types and constants of the depth-preferred hash table
// Table geometry, item layouts, command codes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package dpht_pkg;

    localparam int TABLE_ENTRIES = 65536;

    localparam int KEY_W     = 64;
    localparam int CFG_W     = 17;
    localparam int CFG_RESET = 65536;
    localparam int IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);

    // key bits folded into the remainder per cycle
    localparam int MOD_BITS  = 4;
    localparam int MOD_STEPS = KEY_W / MOD_BITS;
    localparam int STEP_W    = $clog2(MOD_STEPS);

    localparam logic [1:0] CMD_PROBE = 2'd0;
    localparam logic [1:0] CMD_STORE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [KEY_W-1:0]   key;
        logic [7:0]         new_depth;
        logic signed [15:0] new_score;
        logic [1:0]         new_flag;
        logic [15:0]        new_move;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic [7:0]         found_depth;
        logic signed [15:0] found_score;
        logic [1:0]         found_flag;
        logic [15:0]        found_move;
    } t_out_item;

    typedef struct packed {
        logic [7:0]         depth;
        logic [1:0]         flag;
        logic [15:0]        move;
        logic signed [15:0] score;
    } t_payload;

    typedef struct packed {
        logic [KEY_W-1:0] tag;
        t_payload         payload;
    } t_entry;

    typedef struct packed {
        logic in_ready;
        logic ld_in;
        logic mod_step;
        logic rd;
        logic check;
        logic sweep;
        logic out_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] in_cmd;
        logic       sweep_last;
        logic       out_free;
    } t_dp_stat;

    // entry count as used for indexing: zero reads as one, too large as the table size
    function automatic logic [CNT_W-1:0] f_clamp_count(logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] n;
        if (v == '0) begin
            n = CNT_W'(1);
        end else if (32'(v) > 32'(TABLE_ENTRIES)) begin
            n = CNT_W'(TABLE_ENTRIES);
        end else begin
            n = CNT_W'(v);
        end
        return n;
    endfunction

endpackage

// ----- hw/rtl/dpht_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpht_in_if: command channel
// Valid/ready channel carrying one probe, store or clear command.
// ----------------------------------------------------------------------------
interface dpht_in_if import dpht_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/dpht_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpht_out_if: result channel
// Valid/ready channel carrying one lookup result per command.
// ----------------------------------------------------------------------------
interface dpht_out_if import dpht_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/dpht_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpht_ctrl: command sequencer
// Steps each command through remainder, read, check/write and result
// delivery, and runs the clear sweeps after reset and on a clear command.
// ----------------------------------------------------------------------------
module dpht_ctrl import dpht_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CHECK,
        S_SWEEP,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep = 1'b1;
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.ld_in    = i_stat.in_valid;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
            end
            S_DONE: begin
                o_cmd.out_ld = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_step  <= '0;
        end else begin
            case (r_state)
                S_INIT: begin
                    if (i_stat.sweep_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_stat.in_valid) begin
                        r_step <= '0;
                        if (i_stat.in_cmd == CMD_PROBE || i_stat.in_cmd == CMD_STORE) begin
                            r_state <= S_MOD;
                        end else if (i_stat.in_cmd == CMD_CLEAR) begin
                            r_state <= S_SWEEP;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MOD: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(MOD_STEPS - 1)) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_state <= S_DONE;
                end
                S_SWEEP: begin
                    if (i_stat.sweep_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_INIT;
                end
            endcase
        end
    end

    // one command at a time: a transfer closes the input until the result is out
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.in_ready && i_stat.in_valid) |=> !o_cmd.in_ready)
        else $error("input reopened right after a transfer");

    a_out_ld_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_ld |-> i_stat.out_free)
        else $error("result loaded over an untaken result");

    a_init_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> (!o_cmd.in_ready && o_cmd.sweep))
        else $error("input open before the reset sweep");

endmodule

// ----- hw/rtl/dpht_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpht_dp: table datapath
// Entry-count register, radix-16 remainder unit, table memory, hit and
// replacement compare, sweep counter and result register.
// ----------------------------------------------------------------------------
module dpht_dp import dpht_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    dpht_in_if.sink          i_in,
    dpht_out_if.source       o_res
);

    logic [CNT_W-1:0] r_slot_count;
    t_in_item         r_item;
    logic [KEY_W-1:0] r_shift;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] n_rem;
    logic [IDX_W-1:0] r_sweep;
    t_entry           r_mem [TABLE_ENTRIES];
    t_entry           r_rd;
    t_out_item        r_res;
    t_out_item        r_out;
    logic             r_out_valid;

    logic [IDX_W-1:0] idx;
    logic             keep;
    logic             hit;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_entry           mem_wdata;

    assign idx = r_rem[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= f_clamp_count(CFG_W'(CFG_RESET));
        end else if (i_cfg_we) begin
            r_slot_count <= f_clamp_count(i_cfg_wdata);
        end
    end

    // restoring remainder, MOD_BITS key bits per cycle, msb first
    always_comb begin
        logic [CNT_W:0] t;
        logic [CNT_W-1:0] rem;
        rem = r_rem;
        for (int i = 0; i < MOD_BITS; i++) begin
            t = {rem, r_shift[KEY_W-1-i]};
            if (t >= {1'b0, r_slot_count}) begin
                t = t - {1'b0, r_slot_count};
            end
            rem = t[CNT_W-1:0];
        end
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_item  <= i_in.data;
            r_shift <= i_in.data.key;
            r_rem   <= '0;
        end else if (i_cmd.mod_step) begin
            r_shift <= r_shift << MOD_BITS;
            r_rem   <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
        end else if (i_cmd.sweep) begin
            r_sweep <= o_stat.sweep_last ? '0 : r_sweep + IDX_W'(1);
        end
    end

    // a zero probe key never hits; for a zero store key an empty slot is kept like an occupied one
    assign hit  = (r_rd.tag != '0) && (r_rd.tag == r_item.key);
    assign keep = (r_rd.payload.depth > r_item.new_depth)
                && ((r_rd.tag != '0) || (r_item.key == '0));

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx;
        mem_wdata = '0;
        if (i_cmd.sweep) begin
            mem_we    = 1'b1;
            mem_waddr = r_sweep;
        end else if (i_cmd.check && r_item.command == CMD_STORE && !keep) begin
            mem_we                = 1'b1;
            mem_wdata.tag         = r_item.key;
            mem_wdata.payload.depth = r_item.new_depth;
            mem_wdata.payload.flag  = r_item.new_flag;
            mem_wdata.payload.move  = r_item.new_move;
            mem_wdata.payload.score = r_item.new_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd <= r_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_res <= '0;
        end else if (i_cmd.check && r_item.command == CMD_PROBE && hit) begin
            r_res.hit         <= 1'b1;
            r_res.found_depth <= r_rd.payload.depth;
            r_res.found_score <= r_rd.payload.score;
            r_res.found_flag  <= r_rd.payload.flag;
            r_res.found_move  <= r_rd.payload.move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out <= r_res;
        end
    end

    assign i_in.ready  = i_cmd.in_ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    assign o_stat.in_valid   = i_in.valid;
    assign o_stat.in_cmd     = i_in.data.command;
    assign o_stat.sweep_last = (r_sweep == IDX_W'(TABLE_ENTRIES - 1));
    assign o_stat.out_free   = !r_out_valid || o_res.ready;

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (r_rem < r_slot_count))
        else $error("slot index not below entry count");

    a_wport_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.sweep && (i_cmd.check || i_cmd.rd || i_cmd.mod_step)))
        else $error("sweep overlaps a table access");

    a_sweep_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sweep && o_stat.sweep_last) |=> (r_sweep == '0))
        else $error("sweep counter did not wrap");

endmodule

// ----- hw/rtl/depth_preferred_hash_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_preferred_hash_table: direct-mapped transposition table
// Probe, store with depth-preferred replacement, and whole-table clear over a
// key-modulo-entry-count slot index.
//
//   channel   dir  signals                      transfer when
//   i_in      in   valid/ready/data (t_in_item)  valid && ready
//   o_res     out  valid/ready/data (t_out_item) valid && ready
//   i_cfg     in   we/wdata (entry count)        we
//
// probe or store: from transfer through the remainder unit (16 steps of 4 key bits),
//   then read, check and load of the result register
// clear: all entries written, one per cycle, then result load; unused code: result load only
// after reset a clearing pass over all TABLE_ENTRIES entries runs with i_in.ready low
// one command in flight; the result register holds until taken, and the next
//   command is taken once the result is loaded
// ----------------------------------------------------------------------------
module depth_preferred_hash_table import dpht_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    dpht_in_if.sink          i_in,
    dpht_out_if.source       o_res
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    dpht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    dpht_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in        (i_in),
        .o_res       (o_res)
    );

endmodule
